>>> hw/rtl/menu_key_autorepeat_assert.svh
// Assertion macros for the menu key auto-repeat RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef MENU_KEY_AUTOREPEAT_ASSERT_SVH
`define MENU_KEY_AUTOREPEAT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MKA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define MKA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/mka_pkg.sv
// Package for the menu key auto-repeat block: action codes, register map,
// hold phase encoding and the press decoder. No dependencies.
package mka_pkg;

	localparam int unsigned BTN_W    = 12;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned ACT_W    = 4;
	localparam int unsigned PADDR_W  = 3;
	localparam int unsigned PDATA_W  = 32;
	localparam int unsigned IN_TDATA_W  = 48;
	localparam int unsigned OUT_TDATA_W = 8;

	localparam logic [TIME_W-1:0] INITIAL_DELAY_RST   = 32'd500000;
	localparam logic [TIME_W-1:0] REPEAT_INTERVAL_RST = 32'd100000;

	// register index = paddr[2]
	localparam logic REG_INITIAL_DELAY   = 1'b0;
	localparam logic REG_REPEAT_INTERVAL = 1'b1;

	localparam logic [ACT_W-1:0] ACT_NONE      = 4'd0;
	localparam logic [ACT_W-1:0] ACT_BACK      = 4'd1;
	localparam logic [ACT_W-1:0] ACT_EXIT      = 4'd2;
	localparam logic [ACT_W-1:0] ACT_SELECT    = 4'd3;
	localparam logic [ACT_W-1:0] ACT_UP        = 4'd4;
	localparam logic [ACT_W-1:0] ACT_DOWN      = 4'd5;
	localparam logic [ACT_W-1:0] ACT_LEFT      = 4'd6;
	localparam logic [ACT_W-1:0] ACT_RIGHT     = 4'd7;
	localparam logic [ACT_W-1:0] ACT_PAGE_UP   = 4'd8;
	localparam logic [ACT_W-1:0] ACT_PAGE_DOWN = 4'd9;

	localparam int unsigned BTN_UP     = 0;
	localparam int unsigned BTN_DOWN   = 1;
	localparam int unsigned BTN_LEFT   = 2;
	localparam int unsigned BTN_RIGHT  = 3;
	localparam int unsigned BTN_SQUARE = 4;
	localparam int unsigned BTN_CIRCLE = 5;
	localparam int unsigned BTN_CROSS  = 6;
	localparam int unsigned BTN_L      = 8;
	localparam int unsigned BTN_R      = 9;

	typedef enum logic [2:0] {
		PH_NOT_HELD = 3'b001,
		PH_INITIAL  = 3'b010,
		PH_REPEAT   = 3'b100
	} phase_t;

	typedef struct packed {
		logic [TIME_W-1:0] initial_delay_us;
		logic [TIME_W-1:0] repeat_interval_us;
	} cfg_t;

	// the first matching check wins: R has the highest priority, square the lowest
	function automatic logic [ACT_W-1:0] decode_press(input logic [BTN_W-1:0] fresh);
		logic [ACT_W-1:0] act;
		priority if (fresh[BTN_R])      act = ACT_PAGE_DOWN;
		else if (fresh[BTN_L])          act = ACT_PAGE_UP;
		else if (fresh[BTN_RIGHT])      act = ACT_RIGHT;
		else if (fresh[BTN_LEFT])       act = ACT_LEFT;
		else if (fresh[BTN_DOWN])       act = ACT_DOWN;
		else if (fresh[BTN_UP])         act = ACT_UP;
		else if (fresh[BTN_CIRCLE])     act = ACT_SELECT;
		else if (fresh[BTN_CROSS])      act = ACT_EXIT;
		else if (fresh[BTN_SQUARE])     act = ACT_BACK;
		else                            act = ACT_NONE;
		return act;
	endfunction

endpackage

>>> hw/rtl/menu_key_autorepeat.sv
// Menu key auto-repeat: converts button polls into menu action codes with
// typematic repeat. Top level; depends on mka_pkg and mka_hold.
//
// Usage:
//  - s_axis: one transaction per button poll; tdata carries button_bits and
//    the microsecond timestamp now_us.
//  - m_axis: exactly one transaction per poll, tdata carries menu_action
//    (0 when nothing fires), in poll order.
//  - APB: initial_delay_us at 0x0, repeat_interval_us at 0x4; write only
//    while no poll is in flight.
// An accepted poll sits in an input register; the decode/compare/update logic
// then loads the result register once it is empty or its result is taken.
// Throughput is one poll per cycle while m_axis does not stall; the input
// register lets a new poll be taken while the last result still waits.
// A stalled m_axis holds the result; the input register then fills and
// s_axis_tready drops until the result is taken.
// Reset clears all hold state and loads the default delays (500000/100000).
module menu_key_autorepeat (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [11:0] button_bits, [43:12] now_us, [47:44] zero
	input  logic [mka_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [3:0] menu_action, [7:4] zero
	output logic [mka_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mka_pkg::PADDR_W-1:0]         paddr,
	input  logic [mka_pkg::PDATA_W-1:0]         pwdata,
	output logic [mka_pkg::PDATA_W-1:0]         prdata,
	output logic                                pready
);

	mka_pkg::cfg_t                  cfg_q;
	logic                           valid_s1;
	logic [mka_pkg::BTN_W-1:0]      bits_s1;
	logic [mka_pkg::TIME_W-1:0]     now_s1;
	logic                           out_valid_q;
	logic [mka_pkg::ACT_W-1:0]      action_q;
	logic [mka_pkg::ACT_W-1:0]      action;
	logic                           advance;
	logic                           in_take;
	logic                           cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.initial_delay_us   <= mka_pkg::INITIAL_DELAY_RST;
			cfg_q.repeat_interval_us <= mka_pkg::REPEAT_INTERVAL_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				mka_pkg::REG_INITIAL_DELAY:   cfg_q.initial_delay_us   <= pwdata;
				mka_pkg::REG_REPEAT_INTERVAL: cfg_q.repeat_interval_us <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			mka_pkg::REG_INITIAL_DELAY:   prdata = cfg_q.initial_delay_us;
			mka_pkg::REG_REPEAT_INTERVAL: prdata = cfg_q.repeat_interval_us;
			default:                      prdata = '0;
		endcase
	end

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			bits_s1 <= s_axis_tdata[mka_pkg::BTN_W-1:0];
			now_s1  <= s_axis_tdata[mka_pkg::BTN_W +: mka_pkg::TIME_W];
		end
		if (advance) begin
			action_q <= action;
		end
	end

	mka_hold u_hold (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.button_bits (bits_s1),
		.now_us      (now_s1),
		.cfg         (cfg_q),
		.menu_action (action)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(mka_pkg::OUT_TDATA_W - mka_pkg::ACT_W){1'b0}}, action_q};

endmodule

>>> hw/rtl/mka_hold.sv
// Hold tracker: press detection, action decode and typematic repeat timing.
// Depends on mka_pkg and menu_key_autorepeat_assert.svh.
`include "menu_key_autorepeat_assert.svh"

module mka_hold (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic [mka_pkg::BTN_W-1:0]    button_bits,
	input  logic [mka_pkg::TIME_W-1:0]   now_us,
	input  mka_pkg::cfg_t                cfg,
	output logic [mka_pkg::ACT_W-1:0]    menu_action
);

	logic [mka_pkg::BTN_W-1:0]  prev_q;
	mka_pkg::phase_t            phase_q;
	logic [mka_pkg::TIME_W-1:0] mark_q;
	logic [mka_pkg::BTN_W-1:0]  mask_q;
	logic [mka_pkg::ACT_W-1:0]  rep_act_q;

	logic [mka_pkg::BTN_W-1:0]  fresh;
	logic [mka_pkg::ACT_W-1:0]  press_act;
	logic [mka_pkg::TIME_W-1:0] elapsed;
	logic                       held;
	logic                       fire;
	mka_pkg::phase_t            phase_d;

	assign fresh     = ~prev_q & button_bits;
	assign press_act = mka_pkg::decode_press(fresh);
	assign held      = |(button_bits & mask_q);
	assign elapsed   = now_us - mark_q;

	always_comb begin
		fire    = 1'b0;
		phase_d = phase_q;
		unique case (phase_q)
			mka_pkg::PH_INITIAL: begin
				if (elapsed > cfg.initial_delay_us) begin
					fire    = 1'b1;
					phase_d = mka_pkg::PH_REPEAT;
				end
			end
			mka_pkg::PH_REPEAT: begin
				fire = elapsed > cfg.repeat_interval_us;
			end
			default: begin
				fire = 1'b0;
			end
		endcase
		if (!held || press_act != mka_pkg::ACT_NONE) begin
			fire    = 1'b0;
			phase_d = phase_q;
		end
	end

	assign menu_action = (press_act != mka_pkg::ACT_NONE) ? press_act :
		(fire ? rep_act_q : mka_pkg::ACT_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= '0;
			phase_q   <= mka_pkg::PH_NOT_HELD;
			mark_q    <= '0;
			mask_q    <= '0;
			rep_act_q <= mka_pkg::ACT_NONE;
		end else if (advance) begin
			prev_q <= button_bits;
			if (press_act != mka_pkg::ACT_NONE) begin
				mark_q    <= now_us;
				phase_q   <= mka_pkg::PH_INITIAL;
				mask_q    <= fresh;
				rep_act_q <= press_act;
			end else if (fire) begin
				mark_q  <= now_us;
				phase_q <= phase_d;
			end
		end
	end

	`MKA_ASSERT_NEXT(a_press_starts_hold, clk, arst_n,
		advance && press_act != mka_pkg::ACT_NONE,
		phase_q == mka_pkg::PH_INITIAL && mark_q == $past(now_us),
		"new press did not start hold tracking")
	`MKA_ASSERT_NOW(a_repeat_needs_hold, clk, arst_n,
		fire,
		held && (phase_q == mka_pkg::PH_INITIAL || phase_q == mka_pkg::PH_REPEAT),
		"repeat fired without an active hold")
	`MKA_ASSERT_NEXT(a_state_frozen_idle, clk, arst_n,
		!advance,
		$stable(mark_q) && $stable(phase_q) && $stable(prev_q),
		"hold state changed without a transaction")

endmodule

>>> dv/tb_menu_key_autorepeat.sv
// Testbench for menu_key_autorepeat: drives button polls over the stream input and checks
// every menu action against an in-bench model of press decoding and hold repeat timing.
// Depends on mka_pkg and the menu_key_autorepeat RTL only.
`timescale 1ns / 100ps

module tb_menu_key_autorepeat;
	import mka_pkg::*;

	localparam int unsigned BTN_TRIANGLE = 7;
	localparam int unsigned BTN_START = 10;
	localparam int unsigned BTN_SELECT = 11;
	localparam logic [BTN_W-1:0] UNMAPPED_BTNS =
		(12'd1 << BTN_TRIANGLE) | (12'd1 << BTN_START) | (12'd1 << BTN_SELECT);
	localparam int WATCHDOG_LIMIT = 4000;

	// expected menu actions, in poll order, plus the hold tracking that produces them
	class action_scoreboard;
		logic [TIME_W-1:0] first_delay;
		logic [TIME_W-1:0] next_delay;
		logic [BTN_W-1:0] last_bits;
		phase_t hold;
		logic [TIME_W-1:0] hold_start;
		logic [BTN_W-1:0] hold_mask;
		logic [ACT_W-1:0] hold_action;
		logic [ACT_W-1:0] actions_due[$];
		int errors;

		function new();
			first_delay = 32'd500000;
			next_delay = 32'd100000;
			last_bits = '0;
			hold = PH_NOT_HELD;
			hold_start = '0;
			hold_mask = '0;
			hold_action = ACT_NONE;
			errors = 0;
		endfunction

		function void set_register(logic idx, logic [TIME_W-1:0] value);
			if (idx == REG_INITIAL_DELAY)
				first_delay = value;
			else
				next_delay = value;
		endfunction

		// later entries override earlier ones
		function logic [ACT_W-1:0] press_action(logic [BTN_W-1:0] fresh);
			logic [ACT_W-1:0] act;
			act = ACT_NONE;
			if (fresh[BTN_SQUARE]) act = ACT_BACK;
			if (fresh[BTN_CROSS]) act = ACT_EXIT;
			if (fresh[BTN_CIRCLE]) act = ACT_SELECT;
			if (fresh[BTN_UP]) act = ACT_UP;
			if (fresh[BTN_DOWN]) act = ACT_DOWN;
			if (fresh[BTN_LEFT]) act = ACT_LEFT;
			if (fresh[BTN_RIGHT]) act = ACT_RIGHT;
			if (fresh[BTN_L]) act = ACT_PAGE_UP;
			if (fresh[BTN_R]) act = ACT_PAGE_DOWN;
			return act;
		endfunction

		function void note_poll(logic [BTN_W-1:0] bits, logic [TIME_W-1:0] now);
			logic [BTN_W-1:0] fresh;
			logic [ACT_W-1:0] act;
			logic [TIME_W-1:0] elapsed;
			fresh = ~last_bits & bits;
			act = press_action(fresh);
			elapsed = now - hold_start;
			last_bits = bits;
			if (act != ACT_NONE) begin
				hold_start = now;
				hold = PH_INITIAL;
				hold_mask = fresh;
				hold_action = act;
			end else if ((bits & hold_mask) != '0) begin
				if (hold == PH_INITIAL && elapsed > first_delay) begin
					act = hold_action;
					hold_start = now;
					hold = PH_REPEAT;
				end else if (hold == PH_REPEAT && elapsed > next_delay) begin
					act = hold_action;
					hold_start = now;
				end
			end
			actions_due.push_back(act);
		endfunction

		function void check_action(logic [ACT_W-1:0] got);
			logic [ACT_W-1:0] want;
			if (actions_due.size() == 0) begin
				$error("menu_action: no transaction expected, got %0d", got);
				errors++;
			end else begin
				want = actions_due.pop_front();
				if (got !== want) begin
					$error("menu_action: expected %0d, got %0d", want, got);
					errors++;
				end
			end
		endfunction

		function int pending();
			return actions_due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;	// [11:0] button_bits, [43:12] now_us, [47:44] zero
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;	// [3:0] menu_action, [7:4] zero
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	action_scoreboard board = new();
	logic [TIME_W-1:0] clock_us = '0;
	int burst_left = 0;
	int polls_sent = 0;
	int rx_count = 0;
	int quiet_cycles = 0;
	bit steady = 1'b0;

	menu_key_autorepeat i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// result side: check each transaction, stall in runs of random length unless steady
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_action(m_axis_tdata[ACT_W-1:0]);
		if (steady) begin
			m_axis_tready <= 1'b1;
		end else if (rx_count != 0) begin
			rx_count--;
		end else if (m_axis_tready) begin
			m_axis_tready <= 1'b0;
			rx_count = $urandom_range(0, 9);
		end else begin
			m_axis_tready <= 1'b1;
			rx_count = $urandom_range(0, 24);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic [BTN_W-1:0] btn(int unsigned idx);
		return 12'd1 << idx;
	endfunction

	function automatic int unsigned mapped_button();
		int unsigned b;
		b = $urandom_range(0, 8);
		if (b >= BTN_TRIANGLE)
			b++;
		return b;
	endfunction

	task automatic send_poll(input logic [BTN_W-1:0] bits, input logic [TIME_W-1:0] now);
		int gap;
		gap = 0;
		if (!steady && burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 30);
		end
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0000, now, bits};
		do @(posedge clk); while (!s_axis_tready);
		board.note_poll(bits, now);
		polls_sent++;
		clock_us = now;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	task automatic write_reg(input logic idx, input logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.set_register(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_reg(input logic idx, input logic [PDATA_W-1:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			$error("%s: expected %0h, got %0h",
				(idx == REG_INITIAL_DELAY) ? "initial_delay_us" : "repeat_interval_us",
				want, prdata);
			board.errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [TIME_W-1:0] first, input logic [TIME_W-1:0] next);
		drain();
		write_reg(REG_INITIAL_DELAY, first);
		write_reg(REG_REPEAT_INTERVAL, next);
		check_reg(REG_INITIAL_DELAY, first);
		check_reg(REG_REPEAT_INTERVAL, next);
	endtask

	// press, then hold with timestamps placed around the active threshold
	task automatic hold_sequence();
		logic [BTN_W-1:0] press;
		logic [BTN_W-1:0] held;
		logic [TIME_W-1:0] th;
		logic [TIME_W-1:0] d;
		press = btn(mapped_button());
		if ($urandom_range(0, 3) == 0)
			press |= btn(mapped_button());
		if ($urandom_range(0, 3) == 0)
			press |= 12'($urandom) & UNMAPPED_BTNS;
		if ($urandom_range(0, 1) == 0)
			send_poll('0, clock_us + 32'($urandom_range(0, 50)));
		send_poll(press, clock_us + 32'($urandom_range(0, 50)));
		repeat ($urandom_range(1, 10)) begin
			held = press;
			if ($urandom_range(0, 5) == 0)
				held &= 12'($urandom);
			if ($urandom_range(0, 7) == 0)
				held |= 12'($urandom) & UNMAPPED_BTNS;
			th = (board.hold == PH_REPEAT) ? board.next_delay : board.first_delay;
			case ($urandom_range(0, 6))
				0: d = th;
				1: d = th + 1;
				2: d = th - 1;
				3: d = $urandom_range(0, 3);
				4: d = $urandom;
				default: d = th + $urandom_range(0, 40) - 20;
			endcase
			send_poll(held, ($urandom_range(0, 1) ? board.hold_start : clock_us) + d);
		end
	endtask

	task automatic run_random(input int n);
		int target;
		target = polls_sent + n;
		while (polls_sent < target) begin
			if ($urandom_range(0, 3) != 0) begin
				hold_sequence();
			end else begin
				repeat ($urandom_range(1, 4))
					send_poll(12'($urandom), $urandom_range(0, 1) ? 32'($urandom) :
						clock_us + 32'($urandom_range(0, 1000)));
			end
		end
	endtask

	initial begin
		logic [TIME_W-1:0] t;
		logic [BTN_W-1:0] press;
		int unsigned stack_order[7];
		stack_order = '{BTN_CIRCLE, BTN_UP, BTN_DOWN, BTN_LEFT, BTN_RIGHT, BTN_L, BTN_R};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_reg(REG_INITIAL_DELAY, INITIAL_DELAY_RST);
		check_reg(REG_REPEAT_INTERVAL, REPEAT_INTERVAL_RST);

		// hold square: equal to the delay does not fire, one more does
		t = 32'd1000;
		send_poll('0, 32'd0);
		send_poll(btn(BTN_SQUARE), t);
		send_poll(btn(BTN_SQUARE), t + INITIAL_DELAY_RST);
		t = t + INITIAL_DELAY_RST + 1;
		send_poll(btn(BTN_SQUARE), t);
		send_poll(btn(BTN_SQUARE), t + REPEAT_INTERVAL_RST);
		t = t + REPEAT_INTERVAL_RST + 1;
		send_poll(btn(BTN_SQUARE), t);
		send_poll('0, t + 32'd5000000);

		// priority: each added button is the only fresh one
		press = btn(BTN_SQUARE) | btn(BTN_CROSS);
		send_poll(press, t);
		foreach (stack_order[i]) begin
			press |= btn(stack_order[i]);
			send_poll(press, t);
		end

		// unmapped buttons alone do nothing, but join the repeat mask
		send_poll('0, t);
		send_poll(UNMAPPED_BTNS, t);
		send_poll('0, t);
		send_poll(btn(BTN_SQUARE) | btn(BTN_TRIANGLE) | btn(BTN_START), t);
		send_poll(btn(BTN_TRIANGLE), t + INITIAL_DELAY_RST + 1);

		// all buttons at once, repeat across the timestamp wrap
		send_poll('0, t);
		t = 32'hFFFF_FFF0;
		send_poll('1, t);
		send_poll('1, t + INITIAL_DELAY_RST + 1);
		send_poll('0, 32'hFFFF_FFFF);

		configure(32'd40, 32'd10);
		run_random(200);
		configure('0, '0);
		run_random(150);
		configure('1, '1);
		run_random(100);
		configure('0, '1);
		run_random(100);
		configure('1, '0);
		run_random(100);
		steady = 1'b1;
		configure($urandom, $urandom);
		run_random(150);
		steady = 1'b0;
		configure($urandom_range(0, 300), $urandom_range(0, 100));
		run_random(100);
		drain();
		run_random(100);
		configure(INITIAL_DELAY_RST, REPEAT_INTERVAL_RST);
		run_random(100);

		drain();
		repeat (8) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
